[rtl/core/tsd_pkg.sv]
package tsd_pkg;

   localparam int unsigned BYTE_W    = 8;
   localparam int unsigned LEN_W     = 24;
   localparam int unsigned CSR_IDX_W = 2;

   // Number of big-endian length bytes in an item header.
   localparam logic [1:0] LEN_BYTES = 2'd3;
   // Declared length that an integer item must carry.
   localparam logic [LEN_W-1:0] INT_LEN = 24'd8;

   localparam logic [CSR_IDX_W-1:0] CSR_NULL_CODE    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FALSE_CODE   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TRUE_CODE    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_INTEGER_CODE = 2'd3;

   localparam logic [BYTE_W-1:0] NULL_CODE_RST    = 8'd0;
   localparam logic [BYTE_W-1:0] FALSE_CODE_RST   = 8'd1;
   localparam logic [BYTE_W-1:0] TRUE_CODE_RST    = 8'd2;
   localparam logic [BYTE_W-1:0] INTEGER_CODE_RST = 8'd3;

   typedef enum logic [1:0] {
      PH_TYPE  = 2'd0,
      PH_LEN   = 2'd1,
      PH_VALUE = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      ROLE_TYPE    = 2'd0,
      ROLE_LEN     = 2'd1,
      ROLE_VALUE   = 2'd2,
      ROLE_DISCARD = 2'd3
   } role_type;

   typedef enum logic [2:0] {
      ST_RUN  = 3'd0,
      ST_OK   = 3'd1,
      ST_END  = 3'd2,
      ST_MORE = 3'd3,
      ST_BAD  = 3'd4
   } status_type;

   typedef struct packed {
      logic [BYTE_W-1:0] null_code;
      logic [BYTE_W-1:0] false_code;
      logic [BYTE_W-1:0] true_code;
      logic [BYTE_W-1:0] integer_code;
   } codes_type;

   typedef struct packed {
      logic [BYTE_W-1:0] data_byte;
      role_type          byte_role;
      logic [BYTE_W-1:0] item_type;
      logic [LEN_W-1:0]  item_length;
      logic              item_done;
      status_type        status;
   } result_type;

endpackage

[rtl/core/tlv_stream_deframer_core.sv]
// Type-length-value stream deframer.
// A buffer enters on the req_ channel one byte per request, with
// req_end_of_buffer set on its final byte. For every request the rsp_ channel
// delivers exactly one response that tags the byte as type, length, value or
// discarded byte, shows the current item's type and length, flags a completed
// item and reports the status of the buffer.
// The csr_ channel writes the null, false, true and integer type codes; it is
// always ready and should be written only while no request is in flight.
// A request passes through one input register, the parse logic and one
// response register. Throughput is one byte per clock while rsp_ready
// holds, set by the single parse step between the two registers.
// When the receiver stalls, the response register holds and the input
// register still takes one more request; after that req_ready drops until
// the response is taken, so no request is lost.
// Reset empties both registers, returns the parser to expect a type byte
// and restores the default type codes. The parser state also returns to
// that point after the final byte of each buffer.
module tlv_stream_deframer_core
   import tsd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [BYTE_W-1:0]    req_in_byte,
   input  logic                 req_end_of_buffer,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [BYTE_W-1:0]    rsp_data_byte,
   output logic [1:0]           rsp_byte_role,
   output logic [BYTE_W-1:0]    rsp_item_type,
   output logic [LEN_W-1:0]     rsp_item_length,
   output logic                 rsp_item_done,
   output logic [2:0]           rsp_status,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [BYTE_W-1:0]    csr_data
);

   codes_type         codes;
   result_type        result;

   logic              in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0] in_byte_ff;
   logic              in_last_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   result_type        rsp_ff;
   logic              step_en;
   logic              req_take;

   tsd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .codes     (codes)
   );

   tsd_parse u_parse (
      .clock   (clock),
      .reset   (reset),
      .codes   (codes),
      .step_en (step_en),
      .in_byte (in_byte_ff),
      .last    (in_last_ff),
      .result  (result)
   );

   // A byte moves into the response register whenever that register is free
   // or being emptied in the same cycle.
   assign step_en   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || step_en;
   assign req_take  = req_valid && req_ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (step_en) begin
         in_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (step_en) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_in_byte;
         in_last_ff <= req_end_of_buffer;
      end
      if (step_en) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data_byte   = rsp_ff.data_byte;
   assign rsp_byte_role   = rsp_ff.byte_role;
   assign rsp_item_type   = rsp_ff.item_type;
   assign rsp_item_length = rsp_ff.item_length;
   assign rsp_item_done   = rsp_ff.item_done;
   assign rsp_status      = rsp_ff.status;

endmodule

[rtl/core/tsd_csr.sv]
module tsd_csr
   import tsd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [BYTE_W-1:0]    csr_data,
   output codes_type            codes
);

   codes_type codes_ff;
   codes_type codes_in;

   assign csr_ready = 1'b1;
   assign codes     = codes_ff;

   always_comb begin
      codes_in = codes_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_NULL_CODE:    codes_in.null_code    = csr_data;
            CSR_FALSE_CODE:   codes_in.false_code   = csr_data;
            CSR_TRUE_CODE:    codes_in.true_code    = csr_data;
            CSR_INTEGER_CODE: codes_in.integer_code = csr_data;
            default:          codes_in = codes_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         codes_ff.null_code    <= NULL_CODE_RST;
         codes_ff.false_code   <= FALSE_CODE_RST;
         codes_ff.true_code    <= TRUE_CODE_RST;
         codes_ff.integer_code <= INTEGER_CODE_RST;
      end else begin
         codes_ff <= codes_in;
      end
   end

endmodule

[rtl/core/tsd_parse.sv]
module tsd_parse
   import tsd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  codes_type         codes,
   input  logic              step_en,
   input  logic [BYTE_W-1:0] in_byte,
   input  logic              last,
   output result_type        result
);

   phase_type         phase_ff, phase_in;
   logic [1:0]        header_count_ff, header_count_in;
   logic [BYTE_W-1:0] type_hold_ff, type_hold_in;
   logic [LEN_W-1:0]  length_hold_ff, length_hold_in;
   logic [LEN_W-1:0]  bytes_left_ff, bytes_left_in;
   logic              error_ff, error_in;

   logic [LEN_W-1:0]  len_shift;
   logic              breach;
   logic              done;
   logic              bad;
   role_type          role;

   assign len_shift = {length_hold_ff[LEN_W-BYTE_W-1:0], in_byte};

   // The type of the current item must agree with every rule whose code it matches.
   always_comb begin
      breach = 1'b0;
      if ((type_hold_ff == codes.null_code) && (len_shift != '0)) breach = 1'b1;
      if ((type_hold_ff == codes.false_code) && (len_shift != '0)) breach = 1'b1;
      if ((type_hold_ff == codes.true_code) && (len_shift != '0)) breach = 1'b1;
      if ((type_hold_ff == codes.integer_code) && (len_shift != INT_LEN)) breach = 1'b1;
   end

   always_comb begin
      phase_in        = phase_ff;
      header_count_in = header_count_ff;
      type_hold_in    = type_hold_ff;
      length_hold_in  = length_hold_ff;
      bytes_left_in   = bytes_left_ff;
      error_in        = error_ff;
      done            = 1'b0;
      bad             = 1'b0;
      role            = ROLE_TYPE;

      if (error_ff) begin
         role = ROLE_DISCARD;
         bad  = 1'b1;
      end else begin
         case (phase_ff)
            PH_LEN: begin
               role            = ROLE_LEN;
               length_hold_in  = len_shift;
               header_count_in = header_count_ff + 2'd1;
               if (header_count_in >= LEN_BYTES) begin
                  if (breach) begin
                     error_in = 1'b1;
                     bad      = 1'b1;
                  end else if (length_hold_in == '0) begin
                     done     = 1'b1;
                     phase_in = PH_TYPE;
                  end else begin
                     bytes_left_in = length_hold_in;
                     phase_in      = PH_VALUE;
                  end
               end
            end
            PH_VALUE: begin
               role          = ROLE_VALUE;
               bytes_left_in = bytes_left_ff - LEN_W'(1);
               if (bytes_left_in == '0) begin
                  done     = 1'b1;
                  phase_in = PH_TYPE;
               end
            end
            default: begin
               role            = ROLE_TYPE;
               type_hold_in    = in_byte;
               length_hold_in  = '0;
               header_count_in = 2'd0;
               bytes_left_in   = '0;
               phase_in        = PH_LEN;
            end
         endcase
      end

      result.data_byte   = in_byte;
      result.byte_role   = role;
      result.item_type   = type_hold_in;
      result.item_length = length_hold_in;
      result.item_done   = done;
      if (bad) begin
         result.status = ST_BAD;
      end else if (done) begin
         result.status = last ? ST_END : ST_OK;
      end else if (last) begin
         result.status = ST_MORE;
      end else begin
         result.status = ST_RUN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (step_en && last)) begin
         phase_ff        <= PH_TYPE;
         header_count_ff <= 2'd0;
         type_hold_ff    <= '0;
         length_hold_ff  <= '0;
         bytes_left_ff   <= '0;
         error_ff        <= 1'b0;
      end else if (step_en) begin
         phase_ff        <= phase_in;
         header_count_ff <= header_count_in;
         type_hold_ff    <= type_hold_in;
         length_hold_ff  <= length_hold_in;
         bytes_left_ff   <= bytes_left_in;
         error_ff        <= error_in;
      end
   end

endmodule
